>>> sv/car_following_position_step_assert.svh
// Assertion macros shared by the car-following position step RTL.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef CAR_FOLLOWING_POSITION_STEP_ASSERT_SVH
`define CAR_FOLLOWING_POSITION_STEP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CFPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CFPS_ASSERT(lbl, prop, msg)
`define CFPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/cfps_pkg.sv
// Types and constants for the car-following position step block.
// No dependencies; used by the vehicle cell and the top level.
`timescale 1ns / 1ps
package cfps_pkg;

  localparam int PosW = 20;
  localparam logic signed [PosW-1:0] PosMax = 20'sd524287;
  localparam logic signed [PosW-1:0] PosMin = -20'sd524288;

  localparam logic [2:0] CFG_FREE_STEP      = 3'd0;
  localparam logic [2:0] CFG_JAM_SPACING    = 3'd1;
  localparam logic [2:0] CFG_DELAY_TICKS    = 3'd2;
  localparam logic [2:0] CFG_ENTRY_INTERVAL = 3'd3;
  localparam logic [2:0] CFG_ROAD_LENGTH    = 3'd4;

  typedef struct packed {
    logic [11:0] free_step;
    logic [15:0] jam_spacing;
    logic [6:0]  delay_ticks;
    logic [9:0]  entry_interval;
    logic [18:0] road_length;
  } cfg_t;

  // Per-tick control shared by every cell.
  typedef struct packed {
    logic        load;      // transaction accepted: fetch delayed history
    logic        adv;       // the token cell updates this cycle
    logic        age_zero;  // delay of one tick: use the leader's fresh position
    logic        cap_ok;    // delayed tick is not before tick zero
    logic [15:0] tick;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [PosW-1:0] position;
    logic                   active;
    logic                   reached_end;
  } cell_res_t;

endpackage

>>> sv/cfps_if.sv
// Handshake interfaces for the input and result channels.
// Depends on nothing; widths follow the field definitions of the block.
`timescale 1ns / 1ps
interface cfps_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] lead_free_step;
  modport source (output valid, output lead_free_step, input ready);
  modport sink (input valid, input lead_free_step, output ready);
endinterface

interface cfps_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         vehicle_index;
  logic signed [19:0] position;
  logic               active;
  logic               reached_end;
  logic               last;
  modport source (output valid, output vehicle_index, output position, output active,
                  output reached_end, output last, input ready);
  modport sink (input valid, input vehicle_index, input position, input active,
                input reached_end, input last, output ready);
endinterface

>>> sv/car_following_position_step.sv
// Car-following position step: one transaction per simulation tick, giving one result
// transaction per vehicle (VEHICLES of them, vehicle 0 first, last set on the final one).
// A tick first fetches every vehicle's delayed history entry in parallel, then a token
// walks the row of vehicle cells, updating one vehicle per cycle, since each follower
// needs its leader's freshly updated position. The token holds while the result register
// is full and not taken. Input ready is low for the whole tick. History needs no clearing
// after reset: a slot is only read once written.
// Depends on cfps_pkg, cfps_if.sv, cfps_cell and car_following_position_step_assert.svh.
`timescale 1ns / 1ps
`include "car_following_position_step_assert.svh"
module car_following_position_step #(
  parameter int VEHICLES  = 20,
  parameter int DELAY_MAX = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [18:0]       cfg_data_i,
  cfps_in_if.sink           in_i,
  cfps_out_if.source        out_o
);

  localparam int Aw = $clog2(DELAY_MAX);
  localparam int Vw = (VEHICLES > 1) ? $clog2(VEHICLES) : 1;

  cfps_pkg::cfg_t      cfg_q;
  cfps_pkg::cell_ctl_t ctl;
  logic [15:0]         tick_q;
  logic [Aw-1:0]       slot_q, rd_slot;
  logic [11:0]         lead_q;
  logic [Vw-1:0]       vidx_q;
  logic                busy, adv, load, last_step;
  logic [8:0]          dcl, age, slot9, rd9;
  logic [VEHICLES-1:0] tok;
  logic signed [cfps_pkg::PosW-1:0] pos_w  [VEHICLES];
  logic signed [cfps_pkg::PosW-1:0] hist_w [VEHICLES];
  cfps_pkg::cell_res_t res_w [VEHICLES];
  cfps_pkg::cell_res_t sel;
  logic [31:0]         vidx_ext;

  logic                             oval_q;
  logic [4:0]                       oidx_q;
  logic signed [cfps_pkg::PosW-1:0] opos_q;
  logic                             oact_q, oend_q, olast_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{free_step: 12'd768, jam_spacing: 16'd1829, delay_ticks: 7'd17,
                 entry_interval: 10'd36, road_length: 19'd512000};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cfps_pkg::CFG_FREE_STEP:      cfg_q.free_step      <= cfg_data_i[11:0];
        cfps_pkg::CFG_JAM_SPACING:    cfg_q.jam_spacing    <= cfg_data_i[15:0];
        cfps_pkg::CFG_DELAY_TICKS:    cfg_q.delay_ticks    <= cfg_data_i[6:0];
        cfps_pkg::CFG_ENTRY_INTERVAL: cfg_q.entry_interval <= cfg_data_i[9:0];
        cfps_pkg::CFG_ROAD_LENGTH:    cfg_q.road_length    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The delay is clamped to the range of the history ring; the leader is read
  // age ticks back, where an age of zero means this very tick.
  always_comb begin
    dcl = {2'd0, cfg_q.delay_ticks};
    if (dcl == 9'd0) begin
      dcl = 9'd1;
    end else if (dcl > 9'(DELAY_MAX)) begin
      dcl = 9'(DELAY_MAX);
    end
    age   = dcl - 9'd1;
    slot9 = 9'(slot_q);
    rd9   = (slot9 >= age) ? (slot9 - age) : (slot9 + 9'(DELAY_MAX) - age);
  end
  assign rd_slot = rd9[Aw-1:0];

  assign busy      = |tok;
  assign load      = in_i.valid & in_i.ready;
  assign adv       = busy & (~oval_q | out_o.ready);
  assign last_step = adv & tok[VEHICLES-1];
  assign in_i.ready = ~busy;

  assign ctl = '{load: load, adv: adv, age_zero: (age == 9'd0),
                 cap_ok: (tick_q >= {7'd0, age}), tick: tick_q};

  for (genvar v = 0; v < VEHICLES; v++) begin : g_cell
    cfps_cell #(.Idx(v), .DelayMax(DELAY_MAX), .Aw(Aw)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_i       (cfg_q),
      .ctl_i       (ctl),
      .wr_slot_i   (slot_q),
      .rd_slot_i   (rd_slot),
      .step_i      ((v == 0) ? lead_q : cfg_q.free_step),
      .tok_i       ((v == 0) ? 1'b0 : tok[(v == 0) ? 0 : v-1]),
      .lead_pos_i  ((v == 0) ? '0 : pos_w[(v == 0) ? 0 : v-1]),
      .lead_hist_i ((v == 0) ? '0 : hist_w[(v == 0) ? 0 : v-1]),
      .tok_o       (tok[v]),
      .pos_o       (pos_w[v]),
      .hist_o      (hist_w[v]),
      .res_o       (res_w[v])
    );
  end

  // Only the token holder contributes to the result.
  always_comb begin
    sel = '0;
    for (int v = 0; v < VEHICLES; v++) begin
      sel = sel | (res_w[v] & {($bits(cfps_pkg::cell_res_t)){tok[v]}});
    end
  end

  assign vidx_ext = 32'(vidx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      slot_q <= '0;
      vidx_q <= '0;
      oval_q <= 1'b0;
    end else begin
      if (load) begin
        vidx_q <= '0;
      end else if (adv) begin
        vidx_q <= vidx_q + Vw'(1);
      end
      if (last_step) begin
        slot_q <= (slot_q == Aw'(DELAY_MAX - 1)) ? '0 : slot_q + Aw'(1);
        if (tick_q != 16'hFFFF) begin
          tick_q <= tick_q + 16'd1;
        end
      end
      if (adv) begin
        oval_q <= 1'b1;
      end else if (out_o.ready) begin
        oval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      lead_q <= in_i.lead_free_step;
    end
    if (adv) begin
      oidx_q  <= vidx_ext[4:0];
      opos_q  <= sel.position;
      oact_q  <= sel.active;
      oend_q  <= sel.reached_end;
      olast_q <= tok[VEHICLES-1];
    end
  end

  assign out_o.valid         = oval_q;
  assign out_o.vehicle_index = oidx_q;
  assign out_o.position      = opos_q;
  assign out_o.active        = oact_q;
  assign out_o.reached_end   = oend_q;
  assign out_o.last          = olast_q;

  `CFPS_ASSERT(a_tok_onehot, $onehot0(tok), "more than one vehicle cell holds the token")
  `CFPS_ASSERT(a_idx_tracks_tok, !busy || tok[vidx_q], "result index does not match token")
  `CFPS_ASSERT_NEXT(a_tick_end, last_step, !busy, "token did not leave the row after the last vehicle")
  `CFPS_ASSERT_NEXT(a_tick_hold, !last_step, $stable(tick_q) && $stable(slot_q), "tick advanced mid-tick")

endmodule

>>> sv/cfps_cell.sv
// One vehicle cell: position, sticky end flag and its ring of past positions.
// Depends on cfps_pkg; instantiated in a row by car_following_position_step.
`timescale 1ns / 1ps
module cfps_cell #(
  parameter int Idx      = 0,
  parameter int DelayMax = 64,
  parameter int Aw       = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cfps_pkg::cfg_t                      cfg_i,
  input  cfps_pkg::cell_ctl_t                 ctl_i,
  input  logic [Aw-1:0]                       wr_slot_i,
  input  logic [Aw-1:0]                       rd_slot_i,
  input  logic [11:0]                         step_i,
  input  logic                                tok_i,
  input  logic signed [cfps_pkg::PosW-1:0]    lead_pos_i,
  input  logic signed [cfps_pkg::PosW-1:0]    lead_hist_i,
  output logic                                tok_o,
  output logic signed [cfps_pkg::PosW-1:0]    pos_o,
  output logic signed [cfps_pkg::PosW-1:0]    hist_o,
  output cfps_pkg::cell_res_t                 res_o
);

  logic signed [cfps_pkg::PosW-1:0] hist_q [DelayMax];
  logic signed [cfps_pkg::PosW-1:0] hist_rd_q;
  logic signed [cfps_pkg::PosW-1:0] pos_q, pos_d;
  logic                             reached_q, reached_d;
  logic                             tok_q;
  logic                             upd;
  logic [25:0]                      start_tick;
  logic                             act;
  logic signed [cfps_pkg::PosW:0]   sum, cap_raw;
  logic signed [cfps_pkg::PosW-1:0] free_pos, cap_pos, lead_val, capped;

  assign upd        = tok_q & ctl_i.adv;
  assign start_tick = 26'(Idx) * 26'(cfg_i.entry_interval);
  assign act        = {10'd0, ctl_i.tick} >= start_tick;

  always_comb begin
    sum      = {pos_q[cfps_pkg::PosW-1], pos_q} + $signed({9'd0, step_i});
    free_pos = (sum > 21'sd524287) ? cfps_pkg::PosMax : sum[cfps_pkg::PosW-1:0];
    lead_val = ctl_i.age_zero ? lead_pos_i : lead_hist_i;
    cap_raw  = {lead_val[cfps_pkg::PosW-1], lead_val} - $signed({5'd0, cfg_i.jam_spacing});
    cap_pos  = (cap_raw < -21'sd524288) ? cfps_pkg::PosMin : cap_raw[cfps_pkg::PosW-1:0];
    capped   = free_pos;
    if ((Idx > 0) && ctl_i.cap_ok && (free_pos > cap_pos)) begin
      capped = cap_pos;
    end
    pos_d     = act ? capped : pos_q;
    reached_d = reached_q | (act & ~pos_d[cfps_pkg::PosW-1] &
                (pos_d[18:0] >= cfg_i.road_length));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      reached_q <= 1'b0;
      tok_q     <= 1'b0;
    end else begin
      if (ctl_i.load) begin
        tok_q <= (Idx == 0);
      end else if (ctl_i.adv) begin
        tok_q <= tok_i;
      end
      if (upd) begin
        pos_q     <= pos_d;
        reached_q <= reached_d;
      end
    end
  end

  // Ring of past positions; a slot is only ever read after it was written.
  always_ff @(posedge clk_i) begin
    if (upd) begin
      hist_q[wr_slot_i] <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      hist_rd_q <= hist_q[rd_slot_i];
    end
  end

  assign tok_o = tok_q;
  assign pos_o = pos_q;
  assign hist_o = hist_rd_q;
  assign res_o = '{position: pos_d, active: act, reached_end: reached_d};

endmodule

>>> tb/car_following_position_step_test.sv
// Self-checking test of the car-following position step block: directed ticks then random
// ticks, every vehicle result compared against a built-in position predictor.
// Depends on cfps_pkg, cfps_if.sv and car_following_position_step.
`timescale 1ns / 1ps
module car_following_position_step_test;

  localparam int NVEH = 20;
  localparam int DMAX = 64;
  localparam int RANDOM_TICKS = 360;
  localparam longint CYCLE_LIMIT = 900000;
  // A register index that names no register; writes to it must be ignored.
  localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

  typedef struct {
    logic [4:0]         vehicle_index;
    logic signed [19:0] position;
    logic               active;
    logic               reached_end;
    logic               last;
  } veh_res_t;

  // One row of the directed table. When chk_v0 is set, vehicle 0's result of this tick
  // must also match the typed-in position, which cross-checks the predictor itself.
  typedef struct {
    logic [11:0]        lead;
    logic               chk_v0;
    logic signed [19:0] v0_pos;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [18:0] cfg_data_i = '0;

  cfps_in_if in_ch ();
  cfps_out_if out_ch ();

  car_following_position_step uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state: its own copy of configuration and of every vehicle's history.
  logic [11:0] m_free_step;
  logic [15:0] m_jam;
  logic [6:0]  m_delay;
  logic [9:0]  m_entry;
  logic [18:0] m_road;
  int          veh_pos [NVEH];
  int          pos_ring [NVEH][DMAX];
  int          ticks_done;
  int          ring_col;
  bit          at_end [NVEH];

  veh_res_t    expected_results[$];
  int          errors = 0;
  int          results_seen = 0;
  int          ticks_sent = 0;
  longint      cycles = 0;
  bit          stall_sink = 1'b0;
  int          stall_left = 0;

  function automatic int clamp_pos(longint x);
    if (x > 524287) return 524287;
    if (x < -524288) return -524288;
    return int'(x);
  endfunction

  task automatic predict_reset();
    m_free_step = 12'd768; m_jam = 16'd1829; m_delay = 7'd17;
    m_entry = 10'd36; m_road = 19'd512000;
    ticks_done = 0; ring_col = 0;
    for (int v = 0; v < NVEH; v++) begin
      veh_pos[v] = 0; at_end[v] = 1'b0;
      for (int k = 0; k < DMAX; k++) pos_ring[v][k] = 0;
    end
  endtask

  // Advances the predictor by one tick and queues the VEHICLES results it yields.
  task automatic predict_tick(input logic [11:0] lead);
    int d, age, rd, p, cap;
    bit act;
    veh_res_t r;
    d = (m_delay < 1) ? 1 : ((m_delay > DMAX) ? DMAX : int'(m_delay));
    for (int v = 0; v < NVEH; v++) begin
      act = ticks_done >= v * int'(m_entry);
      p = veh_pos[v];
      if (act) begin
        p = clamp_pos(longint'(p) + ((v == 0) ? int'(lead) : int'(m_free_step)));
        if (v >= 1 && ticks_done + 1 >= d) begin
          age = d - 1;
          rd = (ring_col + DMAX - age) % DMAX;
          cap = clamp_pos(longint'(pos_ring[v-1][rd]) - int'(m_jam));
          if (p > cap) p = cap;
        end
        if (p >= int'(m_road)) at_end[v] = 1'b1;
      end
      veh_pos[v] = p;
      pos_ring[v][ring_col] = p;
      r.vehicle_index = v[4:0];
      r.position = p[19:0];
      r.active = act;
      r.reached_end = at_end[v];
      r.last = (v == NVEH - 1);
      expected_results.push_back(r);
    end
    ring_col = (ring_col + 1) % DMAX;
    if (ticks_done < 65535) ticks_done++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [18:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      cfps_pkg::CFG_FREE_STEP:      m_free_step = val[11:0];
      cfps_pkg::CFG_JAM_SPACING:    m_jam = val[15:0];
      cfps_pkg::CFG_DELAY_TICKS:    m_delay = val[6:0];
      cfps_pkg::CFG_ENTRY_INTERVAL: m_entry = val[9:0];
      cfps_pkg::CFG_ROAD_LENGTH:    m_road = val[18:0];
      default: ;
    endcase
  endtask

  task automatic drain_results();
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (NVEH + 4) @(negedge clk_i);
  endtask

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  // Offers one tick on the input channel and holds it until the block takes it.
  // Valid is dropped at a falling edge once the tick is taken and raised again at a later one.
  task automatic send_tick(input logic [11:0] lead, input bit with_gaps);
    if (with_gaps) repeat (pick_gap()) @(negedge clk_i);
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.lead_free_step <= lead;
    predict_tick(lead);
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    ticks_sent++;
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.lead_free_step = '0;
    out_ch.ready = 1'b0;
  end

  // Result sink: ready is driven at the falling edge, with random stalls when enabled,
  // mostly single cycles and now and then a long one.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_sink && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
    end else if (stall_sink && $urandom_range(0, 60) == 0) begin
      stall_left = $urandom_range(8, 40);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    veh_res_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with no expectation waiting: vehicle %0d", out_ch.vehicle_index);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_ch.vehicle_index !== e.vehicle_index) begin
          $error("vehicle_index: expected %0d, actual %0d", e.vehicle_index,
                 out_ch.vehicle_index);
          errors++;
        end
        if (out_ch.position !== e.position) begin
          $error("position (vehicle %0d): expected %0d, actual %0d", e.vehicle_index,
                 e.position, out_ch.position);
          errors++;
        end
        if (out_ch.active !== e.active) begin
          $error("active (vehicle %0d): expected %0b, actual %0b", e.vehicle_index,
                 e.active, out_ch.active);
          errors++;
        end
        if (out_ch.reached_end !== e.reached_end) begin
          $error("reached_end (vehicle %0d): expected %0b, actual %0b", e.vehicle_index,
                 e.reached_end, out_ch.reached_end);
          errors++;
        end
        if (out_ch.last !== e.last) begin
          $error("last (vehicle %0d): expected %0b, actual %0b", e.vehicle_index,
                 e.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** car_following_position_step: FAILED **");
      $finish;
    end
  end

  // Directed table: the first ticks after reset, where vehicle 0 is the only active one,
  // so its position is just the running sum of the lead steps, followed by extremes.
  dir_row_t dir_rows[12] = '{
    '{12'd0,    1'b1, 20'sd0},
    '{12'd4095, 1'b1, 20'sd4095},
    '{12'd1,    1'b1, 20'sd4096},
    '{12'd2048, 1'b1, 20'sd6144},
    '{12'd2047, 1'b1, 20'sd8191},
    '{12'hAAA,  1'b1, 20'sd10921},
    '{12'h555,  1'b1, 20'sd12286},
    '{12'd0,    1'b1, 20'sd12286},
    '{12'd4095, 1'b0, 20'sd0},
    '{12'd4095, 1'b0, 20'sd0},
    '{12'd3000, 1'b0, 20'sd0},
    '{12'd17,   1'b0, 20'sd0}
  };

  initial begin
    logic signed [19:0] v0_expected;
    int phase_ticks;
    predict_reset();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, default configuration, no idling.
    foreach (dir_rows[i]) begin
      send_tick(dir_rows[i].lead, 1'b0);
      if (dir_rows[i].chk_v0) begin
        v0_expected = expected_results[expected_results.size() - NVEH].position;
        if (v0_expected !== dir_rows[i].v0_pos) begin
          $error("position (directed row %0d): expected %0d, actual %0d", i,
                 dir_rows[i].v0_pos, v0_expected);
          errors++;
        end
      end
    end
    drain_results();

    // Small entry interval, delay of one, zero jam spacing: all vehicles packed up.
    write_reg(cfps_pkg::CFG_ENTRY_INTERVAL, 19'd1);
    write_reg(cfps_pkg::CFG_DELAY_TICKS, 19'd1);
    write_reg(cfps_pkg::CFG_JAM_SPACING, 19'd0);
    write_reg(cfps_pkg::CFG_FREE_STEP, 19'd4095);
    write_reg(cfps_pkg::CFG_ROAD_LENGTH, 19'd0);
    write_reg(CFG_UNUSED_IDX, 19'h7FFFF);
    for (int i = 0; i < 6; i++) send_tick(12'd4095, 1'b0);
    drain_results();

    // Random phases through several configurations, extremes included.
    stall_sink = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(cfps_pkg::CFG_DELAY_TICKS, 19'd0);
          write_reg(cfps_pkg::CFG_ENTRY_INTERVAL, 19'd0);
          write_reg(cfps_pkg::CFG_JAM_SPACING, 19'd65535);
          write_reg(cfps_pkg::CFG_FREE_STEP, 19'd0);
          write_reg(cfps_pkg::CFG_ROAD_LENGTH, 19'd524287);
        end
        1: begin
          write_reg(cfps_pkg::CFG_DELAY_TICKS, 19'd64);
          write_reg(cfps_pkg::CFG_ENTRY_INTERVAL, 19'd2);
          write_reg(cfps_pkg::CFG_JAM_SPACING, 19'd256);
          write_reg(cfps_pkg::CFG_FREE_STEP, 19'd4095);
          write_reg(cfps_pkg::CFG_ROAD_LENGTH, 19'd200000);
        end
        2: begin
          write_reg(cfps_pkg::CFG_DELAY_TICKS, 19'd127);
          write_reg(cfps_pkg::CFG_ENTRY_INTERVAL, 19'd1023);
          write_reg(cfps_pkg::CFG_FREE_STEP, 19'd3000);
        end
        default: begin
          write_reg(cfps_pkg::CFG_DELAY_TICKS, 19'($urandom_range(1, 40)));
          write_reg(cfps_pkg::CFG_ENTRY_INTERVAL, 19'($urandom_range(1, 8)));
          write_reg(cfps_pkg::CFG_JAM_SPACING, 19'($urandom_range(0, 4000)));
          write_reg(cfps_pkg::CFG_FREE_STEP, 19'($urandom_range(0, 4095)));
          write_reg(cfps_pkg::CFG_ROAD_LENGTH, 19'($urandom_range(0, 524287)));
        end
      endcase
      phase_ticks = RANDOM_TICKS / 6;
      for (int i = 0; i < phase_ticks; i++)
        send_tick(12'($urandom_range(0, 4095)), ($urandom_range(0, 4) != 0));
      drain_results();
    end

    $display("Covered %0d ticks and %0d vehicle results over several configurations,",
             ticks_sent, results_seen);
    $display("including saturation at the road end, out-of-range delays and zero entry.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("** car_following_position_step: PASSED **");
    end else begin
      $display("** car_following_position_step: FAILED **");
    end
    $finish;
  end

endmodule
